FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: port widths, codes and shared types.
package spq_pkg;

	// Default configuration
	localparam int unsigned DEPTH_DEF      = 8;
	localparam int unsigned PRIO_WIDTH_DEF = 8;

	// Fixed port field widths
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned PORT_PRIO_W = 8;
	localparam int unsigned OCC_W       = 4;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned S_TDATA_W   = 40;
	localparam int unsigned M_TDATA_W   = 48;

	// Operation codes carried on s_tuser
	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	// Result status codes carried on m_tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic enq;   // insert new item, shift lower entries back
		logic deq;   // remove head, shift all entries forward
	} cell_ctl_t;

endpackage

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue built as a chain of entry cells.
// The result of an item is registered and is on the master side in the cycle after it is accepted.
// Throughput: one item per cycle; every cell compares and shifts in the same cycle.
// The result register frees as it is taken, so input stalls only while a result waits.
// Reset clears the entry count and the result valid; cell contents are not reset.
module sorted_priority_queue_top #(
	parameter int unsigned DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int unsigned PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] item_value, [39:32] item_priority
	input  logic                           s_tuser,   // [0] cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] out_value, [39:32] out_priority,
	                                                  // [43:40] occupancy, [47:44] zero
	output logic [spq_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  full;
	logic                  empty;
	cell_ctl_t             ctl;
	logic [VALUE_W-1:0]    in_value;
	logic [PRIO_WIDTH-1:0] in_prio;
	logic [PRIO_WIDTH+PORT_PRIO_W-1:0] in_prio_ext;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [DEPTH-1:0]      occupied;
	logic [DEPTH-1:0]      cell_ge;
	logic [VALUE_W-1:0]    cell_value [DEPTH];
	logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];

	logic                  out_valid_q;
	status_t               status_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [PRIO_WIDTH-1:0] out_prio_q;
	logic [CNT_W-1:0]      occ_q;
	status_t               status_d;
	logic [PRIO_WIDTH+PORT_PRIO_W-1:0] out_prio_ext;
	logic [CNT_W+OCC_W-1:0]            occ_ext;

	// Unpack the input item
	assign in_value    = s_tdata[VALUE_W-1:0];
	assign in_prio_ext = {{PRIO_WIDTH{1'b0}}, s_tdata[VALUE_W +: PORT_PRIO_W]};
	assign in_prio     = in_prio_ext[PRIO_WIDTH-1:0];

	// Handshake and chain control
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctl.enq  = accept && (cmd_t'(s_tuser) == CMD_ENQ) && !full;
		ctl.deq  = accept && (cmd_t'(s_tuser) == CMD_DEQ) && !empty;
		count_d  = count_q;
		status_d = ST_DONE;
		if (accept) begin
			if (cmd_t'(s_tuser) == CMD_ENQ) begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end else begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
		end
	end

	// Mark held cells from the count
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occupied[i] = (CNT_W'(i) < count_q);
		end
	end

	// Chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  left_ge;
		logic [VALUE_W-1:0]    left_value;
		logic [PRIO_WIDTH-1:0] left_prio;
		logic [VALUE_W-1:0]    right_value;
		logic [PRIO_WIDTH-1:0] right_prio;

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_value = in_value;
			assign left_prio  = in_prio;
		end else begin : g_body
			assign left_ge    = cell_ge[i-1];
			assign left_value = cell_value[i-1];
			assign left_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_value = cell_value[i];
			assign right_prio  = cell_prio[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occupied[i]),
			.new_value   (in_value),
			.new_prio    (in_prio),
			.left_ge     (left_ge),
			.left_value  (left_value),
			.left_prio   (left_prio),
			.right_value (right_value),
			.right_prio  (right_prio),
			.ge          (cell_ge[i]),
			.value       (cell_value[i]),
			.prio        (cell_prio[i])
		);
	end

	// Entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result; the head leaves only on a successful dequeue
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			occ_q    <= count_d;
			if (ctl.deq) begin
				out_value_q <= cell_value[0];
				out_prio_q  <= cell_prio[0];
			end else begin
				out_value_q <= '0;
				out_prio_q  <= '0;
			end
		end
	end

	// Pack the result item
	assign out_prio_ext = {{PORT_PRIO_W{1'b0}}, out_prio_q};
	assign occ_ext      = {{OCC_W{1'b0}}, occ_q};
	assign m_tvalid     = out_valid_q;
	assign m_tuser      = status_q;
	assign m_tdata      = {{(M_TDATA_W - VALUE_W - PORT_PRIO_W - OCC_W){1'b0}},
	                       occ_ext[OCC_W-1:0],
	                       out_prio_ext[PORT_PRIO_W-1:0],
	                       out_value_q};

endmodule

FILE: rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and trades it with its neighbors.
module spq_cell #(
	parameter int unsigned PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input  logic                         clk,
	input  spq_pkg::cell_ctl_t           ctl,
	input  logic                         occupied,
	input  logic [spq_pkg::VALUE_W-1:0]  new_value,
	input  logic [PRIO_WIDTH-1:0]        new_prio,
	input  logic                         left_ge,
	input  logic [spq_pkg::VALUE_W-1:0]  left_value,
	input  logic [PRIO_WIDTH-1:0]        left_prio,
	input  logic [spq_pkg::VALUE_W-1:0]  right_value,
	input  logic [PRIO_WIDTH-1:0]        right_prio,
	output logic                         ge,
	output logic [spq_pkg::VALUE_W-1:0]  value,
	output logic [PRIO_WIDTH-1:0]        prio
);
	import spq_pkg::*;

	logic [VALUE_W-1:0]    value_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	// Entry stays ahead of the new item when it is held and not lower
	assign ge    = occupied && (prio_q >= new_prio);
	assign value = value_q;
	assign prio  = prio_q;

	// Keep, take the new item, shift back from the left, or shift forward from the right
	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (!ge) begin
				if (left_ge) begin
					value_q <= new_value;
					prio_q  <= new_prio;
				end else begin
					value_q <= left_value;
					prio_q  <= left_prio;
				end
			end
		end else if (ctl.deq) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule
